/* design/bfpc_pkg.sv */
// Shared constants, codes and control types of the bit frequency and pair counter.
`default_nettype none
package bfpc_pkg;

  // Default bit columns in one sample word
  localparam int WORD_BITS_DEF = 32;
  // Counter widths
  localparam int CNT_W   = 32;
  localparam int LIMIT_W = 44;
  // APB data and address widths
  localparam int APB_DW = 64;
  localparam int APB_AW = 3;
  // Register byte address of sample_limit
  localparam logic [APB_AW-1:0] REG_SAMPLE_LIMIT = 3'd0;

  // Operation codes; code 3 is ignored
  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Source of a read result
  typedef enum logic [1:0] {
    RK_LANE    = 2'd0,
    RK_SAMPLES = 2'd1,
    RK_ZERO    = 2'd2
  } rd_kind_t;

  // Control broadcast from the top level to every lane
  typedef struct packed {
    logic       acc;      // add this word's bit
    logic       pair;     // also count the (held, current) pair
    logic       clr;      // zero all counters and the held bit
    logic       rd;       // capture the selected counter
    logic       rd_ones;  // select the ones counter, else a pair counter
    logic [1:0] rd_pat;   // pair pattern {prev, cur}
  } lane_ctl_t;

endpackage
`default_nettype wire

/* design/bfpc_intf.sv */
// Valid/ready channel interfaces for input words and result words.
`default_nettype none
interface bfpc_in_if #(
  parameter int W     = bfpc_pkg::WORD_BITS_DEF,
  parameter int IDX_W = $clog2(5 * W + 1)
);
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [W-1:0]     sample_word;
  logic [IDX_W-1:0] counter_index;

  modport source (output valid, operation, sample_word, counter_index, input ready);
  modport sink   (input valid, operation, sample_word, counter_index, output ready);
endinterface

interface bfpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bfpc_pkg::LIMIT_W-1:0] count_value;

  modport source (output valid, count_value, input ready);
  modport sink   (input valid, count_value, output ready);
endinterface
`default_nettype wire

/* design/bfpc_lane.sv */
// One bit column: held bit, ones counter, four pair counters and read capture.
`default_nettype none
module bfpc_lane (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire bfpc_pkg::lane_ctl_t   ctl,
  input  wire                        bit_in,
  output logic [bfpc_pkg::CNT_W-1:0] rd_val
);
  import bfpc_pkg::*;

  logic                       held_r, held_nxt;
  logic [CNT_W-1:0]           ones_r, ones_nxt;
  logic [3:0][CNT_W-1:0]      pair_r, pair_nxt;
  logic [CNT_W-1:0]           rd_val_r;
  logic [1:0]                 pat;

  assign pat = {held_r, bit_in};

  // Advance counters on an accepted sample, drop them all on clear
  always_comb begin
    held_nxt = held_r;
    ones_nxt = ones_r;
    pair_nxt = pair_r;
    if (ctl.clr) begin
      held_nxt = 1'b0;
      ones_nxt = '0;
      pair_nxt = '0;
    end else if (ctl.acc) begin
      held_nxt = bit_in;
      ones_nxt = ones_r + CNT_W'(bit_in);
      for (int k = 0; k < 4; k++) begin
        if (ctl.pair && (pat == 2'(k))) pair_nxt[k] = pair_r[k] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      ones_r <= '0;
      pair_r <= '0;
    end else begin
      held_r <= held_nxt;
      ones_r <= ones_nxt;
      pair_r <= pair_nxt;
    end
  end

  // Capture the addressed counter of this column for the merge stage
  always_ff @(posedge clk) begin
    if (ctl.rd) rd_val_r <= ctl.rd_ones ? ones_r : pair_r[ctl.rd_pat];
  end

  assign rd_val = rd_val_r;

  // A clear leaves the column at its reset state
  a_clr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (ones_r == '0) && (pair_r == '0) && !held_r)
    else $error("lane not cleared");
  // Only one pair counter moves per sample
  a_one_pair: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc && !ctl.clr |=> $countones({pair_r[0] != $past(pair_r[0]),
      pair_r[1] != $past(pair_r[1]), pair_r[2] != $past(pair_r[2]),
      pair_r[3] != $past(pair_r[3])}) <= 1)
    else $error("more than one pair counter changed");

endmodule
`default_nettype wire

/* design/bfpc_merge.sv */
// Read merge stage: picks the lane result, forms the word and holds it for the sink.
`default_nettype none
module bfpc_merge #(
  parameter int W      = bfpc_pkg::WORD_BITS_DEF,
  parameter int LANE_W = (W > 1) ? $clog2(W) : 1
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               rd_acc,
  input  wire bfpc_pkg::rd_kind_t           rd_kind,
  input  wire  [LANE_W-1:0]                 rd_lane,
  input  wire  [bfpc_pkg::LIMIT_W-1:0]      samples,
  input  wire  [W-1:0][bfpc_pkg::CNT_W-1:0] lane_val,
  output logic                              take_ok,
  bfpc_out_if.source                        out_ch
);
  import bfpc_pkg::*;

  logic               s1_v_r, s1_v_nxt;
  rd_kind_t           s1_kind_r;
  logic [LANE_W-1:0]  s1_lane_r;
  logic [LIMIT_W-1:0] s1_samp_r;
  logic               out_v_r, out_v_nxt;
  logic [LIMIT_W-1:0] out_d_r, out_d_nxt;
  logic               adv;

  // Output register free, or being taken this cycle
  assign adv     = !out_v_r || out_ch.ready;
  assign take_ok = !s1_v_r || adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (rd_acc)   s1_v_nxt = 1'b1;
    else if (adv) s1_v_nxt = 1'b0;
  end

  // Select the lane result, the sample count or zero
  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    if (adv) begin
      out_v_nxt = s1_v_r;
      case (s1_kind_r)
        RK_LANE:    out_d_nxt = LIMIT_W'(lane_val[s1_lane_r]);
        RK_SAMPLES: out_d_nxt = s1_samp_r;
        default:    out_d_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Hold the read selection with the stage
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      s1_kind_r <= rd_kind;
      s1_lane_r <= rd_lane;
      s1_samp_r <= samples;
    end
    out_d_r <= out_d_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.count_value = out_d_r;

  // A read is never taken over a stalled stage
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    rd_acc |-> take_ok)
    else $error("read accepted while merge stage full");
  // A result appears only from a filled stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s1_v_r))
    else $error("result without a pending read");

endmodule
`default_nettype wire

/* design/bit_frequency_and_pair_counter.sv */
// Top level: word intake, sample accounting, APB register, lanes and merge.
//
//  channel  | direction | handshake                 | payload
//  in_ch    | in        | valid/ready               | operation, sample_word, counter_index
//  out_ch   | out       | valid/ready               | count_value
//  APB      | in        | psel/penable/pwrite, pready | paddr, pwdata, prdata (sample_limit)
//
// One word is accepted per clock while in_ch.ready is high. Accumulate and clear
// take effect at the accept edge in every bit-column lane at once; a read passes
// the lane capture register, then the merge register, before it shows on out_ch.
// rst_n is synchronous and active low; counters, held bits and the sample
// count clear at once, sample_limit returns to all ones.
// in_ch.ready drops only while a read waits behind an unaccepted result.
`default_nettype none
module bit_frequency_and_pair_counter #(
  parameter int WORD_BITS = bfpc_pkg::WORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  bfpc_in_if.sink                      in_ch,
  bfpc_out_if.source                   out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [bfpc_pkg::APB_AW-1:0]  paddr,
  input  wire  [bfpc_pkg::APB_DW-1:0]  pwdata,
  output logic [bfpc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import bfpc_pkg::*;

  localparam int IDX_W  = $clog2(5 * WORD_BITS + 1);
  localparam int LANE_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [IDX_W-1:0] PAIR_BASE = IDX_W'(WORD_BITS);
  localparam logic [IDX_W-1:0] SAMP_IDX  = IDX_W'(5 * WORD_BITS);

  logic [LIMIT_W-1:0]            limit_r, limit_nxt;
  logic [LIMIT_W-1:0]            samples_r, samples_nxt;
  logic                          phase_r, phase_nxt;
  logic                          fire, take_ok, acc_ok, rd_acc, clr;
  logic                          cfg_wr;
  lane_ctl_t                     ctl;
  rd_kind_t                      rd_kind;
  logic [LANE_W-1:0]             rd_lane;
  logic [IDX_W-1:0]              idx, pair_off;
  logic [WORD_BITS-1:0][CNT_W-1:0] lane_val;

  assign idx          = in_ch.counter_index;
  assign in_ch.ready  = take_ok;
  assign fire         = in_ch.valid && take_ok;
  assign acc_ok       = fire && (in_ch.operation == OP_ACC) && (samples_r < limit_r);
  assign rd_acc       = fire && (in_ch.operation == OP_READ);
  assign clr          = fire && (in_ch.operation == OP_CLEAR);

  // APB register write and readback
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_SAMPLE_LIMIT);
  assign prdata = (paddr == REG_SAMPLE_LIMIT) ? APB_DW'(limit_r) : '0;
  assign limit_nxt = cfg_wr ? pwdata[LIMIT_W-1:0] : limit_r;

  // Advance sample count and pair phase, restart both on clear
  always_comb begin
    samples_nxt = samples_r;
    phase_nxt   = phase_r;
    if (clr) begin
      samples_nxt = '0;
      phase_nxt   = 1'b1;
    end else if (acc_ok) begin
      samples_nxt = samples_r + LIMIT_W'(1);
      phase_nxt   = !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= '1;
      samples_r <= '0;
      phase_r   <= 1'b1;
    end else begin
      limit_r   <= limit_nxt;
      samples_r <= samples_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Decode the counter index into lane, counter slot and result source
  assign pair_off = idx - PAIR_BASE;
  always_comb begin
    rd_kind = RK_ZERO;
    rd_lane = idx[LANE_W-1:0];
    ctl     = '0;
    if (idx < PAIR_BASE) begin
      rd_kind     = RK_LANE;
      ctl.rd_ones = 1'b1;
    end else if (idx < SAMP_IDX) begin
      rd_kind = RK_LANE;
      rd_lane = pair_off[LANE_W+1:2];
    end else if (idx == SAMP_IDX) begin
      rd_kind = RK_SAMPLES;
    end
    ctl.rd_pat = pair_off[1:0];
    ctl.rd     = rd_acc;
    ctl.acc    = acc_ok;
    ctl.pair   = acc_ok && !phase_r;
    ctl.clr    = clr;
  end

  // One lane per bit column
  for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
    bfpc_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .bit_in (in_ch.sample_word[g]),
      .rd_val (lane_val[g])
    );
  end

  bfpc_merge #(
    .W      (WORD_BITS),
    .LANE_W (LANE_W)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_acc   (rd_acc),
    .rd_kind  (rd_kind),
    .rd_lane  (rd_lane),
    .samples  (samples_r),
    .lane_val (lane_val),
    .take_ok  (take_ok),
    .out_ch   (out_ch)
  );

  // Clear restarts the sample count
  a_clr_samples: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (samples_r == '0) && phase_r)
    else $error("clear did not restart sample count");
  // Samples at or past the limit leave the count alone
  a_limit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (in_ch.operation == OP_ACC) && !(samples_r < limit_r) |=> $stable(samples_r))
    else $error("sample counted past limit");

endmodule
`default_nettype wire

/* sim/bfpc_count_monitor.sv */
// Monitor that predicts every read count of the counter and compares it with the DUT.
`timescale 1ns / 100ps
module bfpc_count_monitor (
  input  wire                         clk,
  input  wire                         rst_n,
  bfpc_in_if                          in_ch,
  bfpc_out_if                         out_ch,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [bfpc_pkg::APB_AW-1:0] paddr,
  input  wire  [bfpc_pkg::APB_DW-1:0] pwdata,
  input  wire                         pready,
  output int                          err_count,
  output int                          pending_reads
);
  import bfpc_pkg::*;

  localparam int COLS       = WORD_BITS_DEF;
  localparam int PATTERNS   = 4;
  localparam int SEEN_INDEX = (PATTERNS + 1) * COLS;

  // Predicted state of the block
  logic [CNT_W-1:0]   ones_tally [COLS];
  logic [CNT_W-1:0]   pair_tally [PATTERNS*COLS];
  logic [COLS-1:0]    held_word;
  logic               pair_phase;
  logic [LIMIT_W-1:0] samples_seen;
  logic [LIMIT_W-1:0] sample_limit;

  // Counts still owed by the DUT, oldest first
  logic [LIMIT_W-1:0] owed_counts [$];

  // Zero every tally and restart the pairing, as after reset
  task automatic clear_tallies();
    for (int b = 0; b < COLS; b++) begin
      ones_tally[b] = '0;
    end
    for (int s = 0; s < PATTERNS * COLS; s++) begin
      pair_tally[s] = '0;
    end
    held_word    = '0;
    pair_phase   = 1'b1;
    samples_seen = '0;
  endtask

  // Add one sample word while below the sample limit; every second sample also closes a pair per column
  task automatic tally_word(input logic [COLS-1:0] word);
    if (samples_seen < sample_limit) begin
      pair_phase = ~pair_phase;
      for (int b = 0; b < COLS; b++) begin
        ones_tally[b] = ones_tally[b] + word[b];
        if (pair_phase) begin
          pair_tally[PATTERNS*b + 2*held_word[b] + word[b]] =
            pair_tally[PATTERNS*b + 2*held_word[b] + word[b]] + 1'b1;
        end
      end
      held_word    = word;
      samples_seen = samples_seen + 1'b1;
    end
  endtask

  // Value a read of this index must return
  function automatic logic [LIMIT_W-1:0] lookup_count(input int idx);
    if (idx < COLS) begin
      return LIMIT_W'(ones_tally[idx]);
    end
    if (idx < SEEN_INDEX) begin
      return LIMIT_W'(pair_tally[idx - COLS]);
    end
    if (idx == SEEN_INDEX) begin
      return samples_seen;
    end
    return '0;
  endfunction

  // Sample all three ports at the rising edge
  always @(posedge clk) begin : watch
    logic [LIMIT_W-1:0] want;
    if (!rst_n) begin
      clear_tallies();
      sample_limit = '1;
      owed_counts.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_SAMPLE_LIMIT) begin
        sample_limit = pwdata[LIMIT_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          OP_ACC:   tally_word(in_ch.sample_word);
          OP_READ:  owed_counts.push_back(lookup_count(int'(in_ch.counter_index)));
          OP_CLEAR: clear_tallies();
          default:  ;  // unused code: drop the word
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_counts.size() == 0) begin
          err_count++;
          $display("%0t: count_value expected none, actual 0x%h", $time,
                   out_ch.count_value);
        end else begin
          want = owed_counts.pop_front();
          if (out_ch.count_value !== want) begin
            err_count++;
            $display("%0t: count_value expected 0x%h, actual 0x%h", $time, want,
                     out_ch.count_value);
          end
        end
      end
    end
    pending_reads = owed_counts.size();
  end

endmodule

/* sim/tb_bit_frequency_and_pair_counter.sv */
// Stimulus, clock, reset and verdict for the bit frequency and pair counter.
`timescale 1ns / 100ps
module tb_bit_frequency_and_pair_counter;
  import bfpc_pkg::*;

  localparam int         HALF_PERIOD     = 2;
  localparam int         RESET_CYCLES    = 5;
  localparam int         N_PHASES        = 8;
  localparam int         WORDS_PER_PHASE = 240;
  localparam int         BURST_READS     = 40;
  localparam int         HOLD_CYCLES     = 150;
  localparam int         SETTLE_CYCLES   = 6;
  localparam int         STALL_LIMIT     = 2000;
  localparam logic [1:0] OP_UNUSED       = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                err_count;
  int                pending_reads;
  int                stall_cycles;
  bit                steady;
  bit                hold_off;
  logic [LIMIT_W-1:0] limits [N_PHASES];

  bfpc_in_if  in_ch ();
  bfpc_out_if out_ch ();

  always #(HALF_PERIOD) clk = ~clk;

  bit_frequency_and_pair_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfpc_count_monitor count_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .err_count     (err_count),
    .pending_reads (pending_reads)
  );

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 30);
      end
    end
  end

  // End the run when no word or register write has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("bit_frequency_and_pair_counter: mismatch");
        $finish;
      end
    end
  end

  // Offer one word, with random idle cycles ahead of it, and hold until accepted
  task automatic send_word(input logic [1:0] op, input logic [31:0] word,
                           input logic [7:0] idx);
    while (!steady && $urandom_range(0, 99) < 30) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.sample_word   <= word;
    in_ch.counter_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random word: mostly samples and reads, some clears and unused codes
  task automatic send_random();
    int          pick;
    logic [1:0]  op;
    logic [31:0] word;
    logic [7:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      op = OP_ACC;
    end else if (pick < 92) begin
      op = OP_READ;
    end else if (pick < 96) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    case ($urandom_range(0, 9))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      idx = 8'($urandom_range(0, 255));
    end else begin
      idx = 8'($urandom_range(0, 160));
    end
    send_word(op, word, idx);
  endtask

  // Drop valid, wait for every owed count, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reads != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write of sample_limit: setup cycle, then access cycle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SAMPLE_LIMIT;
    pwdata  <= {{(APB_DW - LIMIT_W){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_ACC;
    in_ch.sample_word   = '0;
    in_ch.counter_index = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    steady              = 1'b0;
    hold_off            = 1'b0;
    limits[0] = '1;
    limits[1] = '0;
    limits[2] = 44'd1;
    limits[3] = 44'd2;
    limits[4] = 44'd5;
    limits[5] = 44'($urandom_range(3, 40));
    limits[6] = {{(LIMIT_W - 1){1'b1}}, 1'b0};
    limits[7] = {12'($urandom), 32'($urandom)};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-ones and all-zero samples, pair patterns, every index class
    send_word(OP_ACC, 32'hFFFF_FFFF, 8'd0);
    send_word(OP_ACC, 32'h0000_0000, 8'd0);
    send_word(OP_ACC, 32'h5A5A_5A5A, 8'd0);
    send_word(OP_ACC, 32'hA5A5_A5A5, 8'd0);
    send_word(OP_READ, 32'h0, 8'd0);
    send_word(OP_READ, 32'h0, 8'd31);
    send_word(OP_READ, 32'h0, 8'd32);
    send_word(OP_READ, 32'h0, 8'd34);
    send_word(OP_READ, 32'h0, 8'd35);
    send_word(OP_READ, 32'h0, 8'd37);
    send_word(OP_READ, 32'h0, 8'd159);
    send_word(OP_READ, 32'h0, 8'd160);
    send_word(OP_READ, 32'h0, 8'd161);
    send_word(OP_READ, 32'h0, 8'd255);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 8'd0);
    send_word(OP_READ, 32'h0, 8'd160);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 8'd160);
    send_word(OP_READ, 32'h0, 8'd160);
    send_word(OP_READ, 32'h0, 8'd34);
    send_word(OP_ACC, 32'h8000_0001, 8'd0);
    send_word(OP_READ, 32'h0, 8'd31);
    send_word(OP_READ, 32'h0, 8'd160);

    // Hold off the result side while reads keep coming, so the input backs up
    hold_off = 1'b1;
    steady   = 1'b1;
    repeat (BURST_READS) send_word(OP_READ, $urandom, 8'($urandom_range(0, 160)));
    steady = 1'b0;

    // Random phases, one per sample limit; one phase runs without idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_limit(limits[ph]);
      steady = (ph == 2);
      repeat (WORDS_PER_PHASE) send_random();
      steady = 1'b0;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("bit_frequency_and_pair_counter: match");
    end else begin
      $display("bit_frequency_and_pair_counter: mismatch");
    end
    $finish;
  end

endmodule
